// ----- hw/rtl/ragg_pkg.sv -----
// Shared constants, field layout and control/status types for the range aggregate unit
`timescale 1ns / 1ps
`default_nettype none
package ragg_pkg;

   localparam int STORE_DEPTH = 256;
   localparam int VALUE_BITS  = 32;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   localparam int IDX_BITS  = 8;
   localparam int VAL_BITS  = 32;
   localparam int POS_BITS  = 9;
   localparam int OP_BITS   = 2;
   localparam int STEP_BITS = $clog2(VALUE_BITS + 1);

   localparam int IDX_LSB   = 0;
   localparam int VAL_LSB   = IDX_LSB + IDX_BITS;
   localparam int START_LSB = VAL_LSB + VAL_BITS;
   localparam int END_LSB   = START_LSB + POS_BITS;
   localparam int OP_LSB    = END_LSB + POS_BITS;
   localparam int REQ_FIELD_BITS = OP_LSB + OP_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = 32;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [OP_BITS-1:0] OP_SUM = 2'd0;
   localparam logic [OP_BITS-1:0] OP_AVG = 2'd1;
   localparam logic [OP_BITS-1:0] OP_MIN = 2'd2;
   localparam logic [OP_BITS-1:0] OP_MAX = 2'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic load;
      logic wr_en;
      logic rd_issue;
      logic div_start;
      logic out_load;
   } ragg_cmd_type;

   typedef struct packed {
      logic bad_range;
      logic ptr_last;
      logic op_avg;
      logic div_busy;
      logic out_free;
   } ragg_sts_type;

endpackage
`default_nettype wire

// ----- hw/rtl/range_aggregate_sum_avg_min_max_unit.sv -----
// A write word is taken and gives no response.
// A query over N elements reads them from the store one element per cycle;
// an average then runs the one-bit-per-cycle divider before the result is loaded.
// A bad range skips the scan and responds with error status and zero data.
// One query at a time: the next word is taken once the result is out.
// Synchronous active-high reset clears control state; the store is undefined.
`timescale 1ns / 1ps
`default_nettype none
module range_aggregate_sum_avg_min_max_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // element_index, element_value, range_start, range_end, op_kind
   input  wire logic [ragg_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // command
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // result_value
   output logic      [ragg_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // status
   output logic                                      rsp_tuser
);

   ragg_pkg::ragg_cmd_type cmd;
   ragg_pkg::ragg_sts_type sts;

   ragg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   ragg_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/ragg_ram.sv -----
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module ragg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/ragg_div.sv -----
// Iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ragg_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [ragg_pkg::VALUE_BITS-1:0]   dividend,
   input  wire logic [ragg_pkg::POS_BITS-1:0]     divisor,
   output logic                                   busy,
   output logic      [ragg_pkg::VALUE_BITS-1:0]   quotient
);

   logic [ragg_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic [ragg_pkg::VALUE_BITS-1:0] quo_ff, quo_in;
   logic [ragg_pkg::POS_BITS-1:0]   rem_ff, rem_in;
   logic [ragg_pkg::POS_BITS-1:0]   dsr_ff, dsr_in;
   logic [ragg_pkg::POS_BITS:0]     rem_sh;
   logic [ragg_pkg::POS_BITS:0]     rem_diff;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[ragg_pkg::VALUE_BITS-1]};
      rem_diff = rem_sh - {1'b0, dsr_ff};
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         step_in = ragg_pkg::STEP_BITS'(ragg_pkg::VALUE_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_diff[ragg_pkg::POS_BITS-1:0];
            quo_in = {quo_ff[ragg_pkg::VALUE_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[ragg_pkg::POS_BITS-1:0];
            quo_in = {quo_ff[ragg_pkg::VALUE_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = (step_ff != '0);
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/ragg_dpath.sv -----
// Datapath: element store, range pointer, accumulator, divider and result register
`timescale 1ns / 1ps
`default_nettype none
module ragg_dpath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ragg_pkg::ragg_cmd_type               cmd,
   output ragg_pkg::ragg_sts_type                    sts,
   input  wire logic [ragg_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [ragg_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                      rsp_tuser
);

   logic [ragg_pkg::IDX_BITS-1:0]   elem_index;
   logic [ragg_pkg::VAL_BITS-1:0]   elem_value;
   logic [ragg_pkg::POS_BITS-1:0]   range_start;
   logic [ragg_pkg::POS_BITS-1:0]   range_end;
   logic [ragg_pkg::OP_BITS-1:0]    op_kind;

   logic [ragg_pkg::POS_BITS-1:0]   start_ff, start_in;
   logic [ragg_pkg::POS_BITS-1:0]   end_ff, end_in;
   logic [ragg_pkg::OP_BITS-1:0]    op_ff, op_in;
   logic                            err_ff, err_in;
   logic [ragg_pkg::POS_BITS-1:0]   ptr_ff, ptr_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic                            rd_first_ff, rd_first_in;
   logic [ragg_pkg::VALUE_BITS-1:0] acc_ff, acc_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ragg_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_err_ff, rsp_err_in;

   logic                            wr_hit;
   logic [ragg_pkg::VALUE_BITS-1:0] wr_data;
   logic [ragg_pkg::VALUE_BITS-1:0] rd_data;
   logic [ragg_pkg::VALUE_BITS-1:0] acc_mag;
   logic [ragg_pkg::VALUE_BITS-1:0] quotient;
   logic [ragg_pkg::VALUE_BITS-1:0] avg_value;
   logic [ragg_pkg::VALUE_BITS-1:0] result;
   logic [ragg_pkg::POS_BITS-1:0]   count;
   logic                            div_busy;

   assign elem_index  = req_tdata[ragg_pkg::IDX_LSB   +: ragg_pkg::IDX_BITS];
   assign elem_value  = req_tdata[ragg_pkg::VAL_LSB   +: ragg_pkg::VAL_BITS];
   assign range_start = req_tdata[ragg_pkg::START_LSB +: ragg_pkg::POS_BITS];
   assign range_end   = req_tdata[ragg_pkg::END_LSB   +: ragg_pkg::POS_BITS];
   assign op_kind     = req_tdata[ragg_pkg::OP_LSB    +: ragg_pkg::OP_BITS];

   assign wr_hit  = cmd.wr_en && (32'(elem_index) < 32'(ragg_pkg::STORE_DEPTH));
   assign wr_data = ragg_pkg::VALUE_BITS'(signed'(elem_value));

   ragg_ram #(
      .WIDTH (ragg_pkg::VALUE_BITS),
      .DEPTH (ragg_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_hit),
      .wr_addr (ragg_pkg::ADDR_BITS'(elem_index)),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (ragg_pkg::ADDR_BITS'(ptr_ff)),
      .rd_data (rd_data)
   );

   assign count   = end_ff - start_ff;
   assign acc_mag = acc_ff[ragg_pkg::VALUE_BITS-1] ? (~acc_ff + 1'b1) : acc_ff;

   ragg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_mag),
      .divisor  (count),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign avg_value = acc_ff[ragg_pkg::VALUE_BITS-1] ? (~quotient + 1'b1) : quotient;

   always_comb begin
      if (err_ff) begin
         result = '0;
      end else if (op_ff == ragg_pkg::OP_AVG) begin
         result = avg_value;
      end else begin
         result = acc_ff;
      end
   end

   always_comb begin
      start_in     = start_ff;
      end_in       = end_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      ptr_in       = ptr_ff;
      acc_in       = acc_ff;
      rd_vld_in    = cmd.rd_issue;
      rd_first_in  = cmd.rd_issue && (ptr_ff == start_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (cmd.load) begin
         start_in = range_start;
         end_in   = range_end;
         op_in    = op_kind;
         err_in   = sts.bad_range;
         ptr_in   = range_start;
      end else if (cmd.rd_issue) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (rd_vld_ff) begin
         if (rd_first_ff) begin
            acc_in = rd_data;
         end else begin
            case (op_ff)
               ragg_pkg::OP_MIN: begin
                  if ($signed(rd_data) < $signed(acc_ff)) begin
                     acc_in = rd_data;
                  end
               end
               ragg_pkg::OP_MAX: begin
                  if ($signed(rd_data) > $signed(acc_ff)) begin
                     acc_in = rd_data;
                  end
               end
               default: begin
                  acc_in = acc_ff + rd_data;
               end
            endcase
         end
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ragg_pkg::RSP_DATA_BITS'(result);
         rsp_err_in   = err_ff ? ragg_pkg::STATUS_ERR : ragg_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff    <= start_in;
      end_ff      <= end_in;
      op_ff       <= op_in;
      err_ff      <= err_in;
      ptr_ff      <= ptr_in;
      rd_first_ff <= rd_first_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign sts.bad_range = (range_start >= range_end)
                       || (32'(range_end) > 32'(ragg_pkg::STORE_DEPTH));
   assign sts.ptr_last  = (ptr_ff == end_ff - 1'b1);
   assign sts.op_avg    = (op_ff == ragg_pkg::OP_AVG);
   assign sts.div_busy  = div_busy;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/ragg_ctrl.sv -----
// Controller state machine sequencing writes, range scans, division and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module ragg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic                   req_tuser,
   input  wire ragg_pkg::ragg_sts_type sts,
   output ragg_pkg::ragg_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_DRAIN   = 3'd2;
   localparam logic [2:0] S_DIVGO   = 3'd3;
   localparam logic [2:0] S_DIVWAIT = 3'd4;
   localparam logic [2:0] S_OUT     = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.wr_en     = accept && (req_tuser == ragg_pkg::CMD_WRITE);
      cmd.load      = accept && (req_tuser == ragg_pkg::CMD_QUERY);
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = sts.bad_range ? S_OUT : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_issue = 1'b1;
            if (sts.ptr_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = sts.op_avg ? S_DIVGO : S_OUT;
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (!sts.div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ragg_checker.sv -----
// Port-level checker for the range aggregate unit and its bind
`timescale 1ns / 1ps
`default_nettype none
module ragg_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               req_tuser,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [ragg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic                               rsp_tuser
);

   logic req_word;

   assign req_word = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ragg_pkg::STATUS_ERR) |-> rsp_tdata == '0)
      else $error("error response carries non-zero data");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_word && (req_tuser == ragg_pkg::CMD_WRITE) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("write word produced a response");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_word && (req_tuser == ragg_pkg::CMD_QUERY) |=> !req_tready)
      else $error("second word taken while a query is in flight");

endmodule

bind range_aggregate_sum_avg_min_max_unit ragg_checker u_checker (.*);
`default_nettype wire
